// ----- design/key_table_with_hit_count_aging_core_assert.svh -----
// Assertion macros for the key table core.
// Expects clk and rst_n in the scope of every use.
`ifndef KEY_TABLE_WITH_HIT_COUNT_AGING_CORE_ASSERT_SVH
`define KEY_TABLE_WITH_HIT_COUNT_AGING_CORE_ASSERT_SVH

// Same-cycle implication.
`define KTHCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KTHCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/kthca_pkg.sv -----
// Types and constants of the key table core.
// No dependencies.
package kthca_pkg;

    localparam int KEY_W      = 22;
    localparam int STAMP_W    = 32;
    localparam int HITS_W     = 8;
    localparam int FIELD_W    = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [HITS_W-1:0]    HITS_MAX         = 8'hFF;
    localparam logic [STAMP_W-1:0]   AGE_LIMIT_RESET  = 32'd300;
    localparam logic [HITS_W-1:0]    KEEP_COUNT_RESET = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 4'd1;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_EXPIRE = 2'd2,
        CMD_PURGE  = 2'd3
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t          command;
        logic [KEY_W-1:0]   key;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic [HITS_W-1:0]  hit_count;
        logic               dropped;
        logic [FIELD_W-1:0] removed;
        logic [FIELD_W-1:0] occupancy;
    } result_t;

endpackage

// ----- design/key_table_with_hit_count_aging_core.sv -----
// Keyed table with hit counts and idle-timeout aging.
// Depends on kthca_pkg and key_table_with_hit_count_aging_core_assert.svh.
//
// One command at a time: tick and purge go from idle straight to the done
// state, which loads the output register; add and expire walk the table one
// entry per cycle through the single read port of the entry memory and one
// shared key/age compare (an add that hits returns early). A finished result
// waits in the output register while the next command is taken.
module key_table_with_hit_count_aging_core #(
    parameter int ENTRIES = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  kthca_pkg::cmd_t                        in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output kthca_pkg::result_t                     out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [kthca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kthca_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import kthca_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    cmd_code_t           cmd_reg, cmd_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [STAMP_W-1:0]  now_reg, now_next;
    logic [STAMP_W-1:0]  age_limit_reg;
    logic [HITS_W-1:0]   keep_count_reg;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic                chk_reg, chk_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic                free_found_reg, free_found_next;
    logic [IW-1:0]       free_idx_reg, free_idx_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic                res_hit_reg, res_hit_next;
    logic [HITS_W-1:0]   res_hits_reg, res_hits_next;
    logic                res_drop_reg, res_drop_next;
    logic [CW-1:0]       res_removed_reg, res_removed_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_data_reg;
    logic                out_load;
    logic                mem_we;

    logic [KEY_W-1:0]    entry_key   [ENTRIES];
    logic [STAMP_W-1:0]  entry_stamp [ENTRIES];
    logic [HITS_W-1:0]   entry_hits  [ENTRIES];
    logic [KEY_W-1:0]    rd_key_reg;
    logic [STAMP_W-1:0]  rd_stamp_reg;
    logic [HITS_W-1:0]   rd_hits_reg;

    logic                cur_valid;
    logic                cur_last;
    logic [STAMP_W-1:0]  cur_age;
    logic [HITS_W-1:0]   hits_inc;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cur_valid = valid_reg[cur_reg];
    assign cur_last  = (cur_reg == IW'(ENTRIES - 1));
    assign cur_age   = now_reg - rd_stamp_reg;
    assign hits_inc  = (rd_hits_reg == HITS_MAX) ? rd_hits_reg : rd_hits_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_key[slot_reg]   <= key_reg;
            entry_stamp[slot_reg] <= now_reg;
            entry_hits[slot_reg]  <= res_hits_reg;
        end
        rd_key_reg   <= entry_key[idx_reg[IW-1:0]];
        rd_stamp_reg <= entry_stamp[idx_reg[IW-1:0]];
        rd_hits_reg  <= entry_hits[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg  <= AGE_LIMIT_RESET;
            keep_count_reg <= KEEP_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_AGE_LIMIT:  age_limit_reg  <= cfg_data[STAMP_W-1:0];
                CFG_KEEP_COUNT: keep_count_reg <= cfg_data[HITS_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        valid_next       = valid_reg;
        occ_next         = occ_reg;
        idx_next         = idx_reg;
        chk_next         = chk_reg;
        cur_next         = cur_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        slot_next        = slot_reg;
        res_hit_next     = res_hit_reg;
        res_hits_next    = res_hits_reg;
        res_drop_next    = res_drop_reg;
        res_removed_next = res_removed_reg;
        out_load         = 1'b0;
        mem_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next         = in_data.command;
                    key_next         = in_data.key;
                    res_hit_next     = 1'b0;
                    res_hits_next    = '0;
                    res_drop_next    = 1'b0;
                    res_removed_next = '0;
                    case (in_data.command)
                        CMD_TICK:
                        begin
                            now_next   = now_reg + 1'b1;
                            state_next = ST_DONE;
                        end
                        CMD_PURGE:
                        begin
                            res_removed_next = occ_reg;
                            valid_next       = '0;
                            occ_next         = '0;
                            state_next       = ST_DONE;
                        end
                        default:
                        begin
                            idx_next        = '0;
                            chk_next        = 1'b0;
                            free_found_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // issue the next read
                if (idx_reg < CW'(ENTRIES))
                begin
                    cur_next = idx_reg[IW-1:0];
                    chk_next = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                end
                // check the entry read last cycle
                if (chk_reg)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (cur_valid && (rd_key_reg == key_reg))
                        begin
                            slot_next     = cur_reg;
                            res_hit_next  = 1'b1;
                            res_hits_next = hits_inc;
                            state_next    = ST_WRITE;
                        end
                        else
                        begin
                            if (!cur_valid && !free_found_reg)
                            begin
                                free_found_next = 1'b1;
                                free_idx_next   = cur_reg;
                            end
                            if (cur_last)
                            begin
                                if (free_found_reg)
                                begin
                                    slot_next  = free_idx_reg;
                                    state_next = ST_WRITE;
                                end
                                else if (!cur_valid)
                                begin
                                    slot_next  = cur_reg;
                                    state_next = ST_WRITE;
                                end
                                else
                                begin
                                    res_drop_next = 1'b1;
                                    state_next    = ST_DONE;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (cur_valid && (cur_age > age_limit_reg)
                            && (rd_hits_reg < keep_count_reg))
                        begin
                            valid_next[cur_reg] = 1'b0;
                            occ_next            = occ_reg - 1'b1;
                            res_removed_next    = res_removed_reg + 1'b1;
                        end
                        if (cur_last)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_WRITE:
            begin
                mem_we              = 1'b1;
                valid_next[slot_reg] = 1'b1;
                if (!res_hit_reg)
                begin
                    occ_next = occ_reg + 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            valid_reg     <= '0;
            occ_reg       <= '0;
            idx_reg       <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        cur_reg         <= cur_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        slot_reg        <= slot_next;
        res_hit_reg     <= res_hit_next;
        res_hits_reg    <= res_hits_next;
        res_drop_reg    <= res_drop_next;
        res_removed_reg <= res_removed_next;
        if (out_load)
        begin
            out_data_reg.hit       <= res_hit_reg;
            out_data_reg.hit_count <= res_hits_reg;
            out_data_reg.dropped   <= res_drop_reg;
            out_data_reg.removed   <= FIELD_W'(res_removed_reg);
            out_data_reg.occupancy <= FIELD_W'(occ_reg);
        end
    end

    `include "key_table_with_hit_count_aging_core_assert.svh"

    `KTHCA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != ST_IDLE, "command accepted but sequencer stayed idle")
    `KTHCA_ASSERT_NOW(a_occ_matches_valid, 1'b1, occ_reg == CW'($countones(valid_reg)), "occupancy count out of step with valid bits")
    `KTHCA_ASSERT_NOW(a_occ_bound, 1'b1, occ_reg <= CW'(ENTRIES), "occupancy exceeds table size")
    `KTHCA_ASSERT_NOW(a_out_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE), "result presented without finishing a command")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for key_table_with_hit_count_aging_core: directed and random
// table commands, a transaction-level table predictor, and register changes between phases.
// Depends on kthca_pkg and the core RTL only.
module tb_top;

    import kthca_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int TABLE_SLOTS = 16;
    localparam int SETTLE      = TABLE_SLOTS + 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    cmd_t                  in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    result_t               out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cmd_t    cmd_queue[$];
    result_t result_queue[$];
    bit      idle_on = 1'b1;
    bit      in_taken = 1'b0;
    bit      out_taken = 1'b0;
    int      send_gap = 0;
    int      stall_left = 0;
    int      fail_count = 0;

    logic                  table_valid[TABLE_SLOTS];
    logic [KEY_W-1:0]      table_key[TABLE_SLOTS];
    logic [STAMP_W-1:0]    table_stamp[TABLE_SLOTS];
    logic [HITS_W-1:0]     table_hits[TABLE_SLOTS];
    logic [STAMP_W-1:0]    tick_now = '0;
    logic [STAMP_W-1:0]    cur_age_limit = AGE_LIMIT_RESET;
    logic [HITS_W-1:0]     cur_keep_count = KEEP_COUNT_RESET;

    key_table_with_hit_count_aging_core #(
        .ENTRIES (TABLE_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic result_t table_apply(cmd_t c);
        result_t          r;
        int               slot;
        logic [STAMP_W-1:0] age;
        r = '0;
        slot = -1;
        case (c.command)
            CMD_TICK:
            begin
                tick_now = tick_now + 1'b1;
            end
            CMD_ADD:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (slot < 0 && table_valid[i] && table_key[i] == c.key)
                        slot = i;
                end
                if (slot >= 0)
                begin
                    table_stamp[slot] = tick_now;
                    if (table_hits[slot] != HITS_MAX)
                        table_hits[slot] = table_hits[slot] + 1'b1;
                    r.hit = 1'b1;
                    r.hit_count = table_hits[slot];
                end
                else
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (slot < 0 && !table_valid[i])
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        table_valid[slot] = 1'b1;
                        table_key[slot] = c.key;
                        table_stamp[slot] = tick_now;
                        table_hits[slot] = '0;
                    end
                    else
                        r.dropped = 1'b1;
                end
            end
            CMD_EXPIRE:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    age = tick_now - table_stamp[i];
                    if (table_valid[i] && age > cur_age_limit && table_hits[i] < cur_keep_count)
                    begin
                        table_valid[i] = 1'b0;
                        r.removed = r.removed + 1'b1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < TABLE_SLOTS; i++)
                begin
                    if (table_valid[i])
                    begin
                        table_valid[i] = 1'b0;
                        r.removed = r.removed + 1'b1;
                    end
                end
            end
        endcase
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (table_valid[i])
                r.occupancy = r.occupancy + 1'b1;
        end
        return r;
    endfunction

    // advance to the next transaction once the current one is taken
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_queue.size() != 0)
            begin
                in_data <= cmd_queue.pop_front();
                in_valid <= 1'b1;
                send_gap = idle_on ? $urandom_range(15, 0) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (out_taken)
            stall_left = idle_on ? $urandom_range(15, 0) : 0;
        if (out_valid && stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        result_t want;
        in_taken <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (out_valid && !out_stall)
        begin
            if (result_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transaction: %p", out_data);
            end
            else
            begin
                want = result_queue.pop_front();
                if (out_data !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result mismatch: expected %p, got %p", want, out_data);
                end
            end
        end
        if (in_valid && !in_stall)
            result_queue.push_back(table_apply(in_data));
    end

    task automatic queue_cmd(cmd_code_t op, logic [KEY_W-1:0] k);
        cmd_t c;
        c.command = op;
        c.key = k;
        cmd_queue.push_back(c);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_AGE_LIMIT:  cur_age_limit = val;
            CFG_KEEP_COUNT: cur_keep_count = val[HITS_W-1:0];
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || in_valid || result_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic queue_random(int count, int pool_size, int add_pct, int tick_pct,
                                int expire_pct);
        logic [KEY_W-1:0] pool[$];
        logic [KEY_W-1:0] k;
        cmd_code_t        op;
        int               pick;
        for (int i = 0; i < pool_size; i++)
            pool.push_back(KEY_W'($urandom));
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99, 0);
            if ($urandom_range(9, 0) == 0)
                k = KEY_W'($urandom);
            else
                k = pool[$urandom_range(pool_size - 1, 0)];
            if (pick < add_pct)
                op = CMD_ADD;
            else if (pick < add_pct + tick_pct)
                op = CMD_TICK;
            else if (pick < add_pct + tick_pct + expire_pct)
                op = CMD_EXPIRE;
            else
                op = CMD_PURGE;
            queue_cmd(op, k);
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            table_valid[i] = 1'b0;
            table_key[i] = '0;
            table_stamp[i] = '0;
            table_hits[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_cmd(CMD_ADD, '0);
        queue_cmd(CMD_ADD, '1);
        queue_cmd(CMD_ADD, '0);
        queue_cmd(CMD_TICK, '1);
        queue_cmd(CMD_EXPIRE, '0);
        for (int i = 1; i <= 14; i++)
            queue_cmd(CMD_ADD, KEY_W'(i));
        queue_cmd(CMD_ADD, 22'h2AAAAA);
        queue_cmd(CMD_ADD, '1);
        queue_cmd(CMD_PURGE, '0);
        queue_cmd(CMD_EXPIRE, '1);
        queue_cmd(CMD_TICK, '0);
        wait_drained();

        write_reg(CFG_AGE_LIMIT, '0);
        write_reg(CFG_KEEP_COUNT, '0);
        queue_random(150, 20, 50, 35, 12);
        wait_drained();

        write_reg(CFG_KEEP_COUNT, 32'd255);
        queue_random(200, 20, 50, 35, 12);
        wait_drained();

        idle_on = 1'b0;
        write_reg(CFG_AGE_LIMIT, 32'd3);
        write_reg(CFG_KEEP_COUNT, 32'd2);
        queue_random(250, 24, 50, 35, 12);
        wait_drained();

        idle_on = 1'b1;
        write_reg(CFG_AGE_LIMIT, '1);
        write_reg(CFG_KEEP_COUNT, 32'h1234_5608);
        queue_random(150, 30, 60, 25, 12);
        wait_drained();

        // hammer one key long enough to pin its count at the ceiling
        write_reg(CFG_AGE_LIMIT, 32'd5);
        write_reg(CFG_KEEP_COUNT, '1);
        queue_random(550, 1, 96, 3, 1);
        wait_drained();

        write_reg(CFG_SPARE_LO, 32'hDEAD_BEEF);
        write_reg(CFG_SPARE_HI, '1);
        write_reg(CFG_AGE_LIMIT, 32'd300);
        write_reg(CFG_KEEP_COUNT, 32'd5);
        queue_random(100, 16, 50, 35, 12);
        wait_drained();

        if (fail_count == 0 && result_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/kthca_pkg.sv
design/key_table_with_hit_count_aging_core.sv
bench/tb_top.sv
